// File: hw/rtl/ddmm_pkg.sv
// ----------------------------------------------------------------------------
// ddmm_pkg: shared definitions of the deadman drive mode mapper
// Widths, event and register codes, reset values, the mode type and the
// command saturation used by the mapper modules.
// ----------------------------------------------------------------------------
package ddmm_pkg;

    // field widths
    localparam int KIND_W     = 2;
    localparam int NUM_W      = 8;
    localparam int VALUE_W    = 16;
    localparam int MODE_W     = 2;
    localparam int GAIN_W     = 10;
    localparam int LEVEL_W    = 16;
    localparam int CMD_W      = 11;
    localparam int WIDE_W     = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // command limit in both directions
    localparam int CMD_LIMIT = 1023;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_THROTTLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BRAKE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_LEVEL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_LEVEL    = 3'd4;

    // configuration reset values
    localparam logic [GAIN_W-1:0]         RST_MAX_THROTTLE = 10'd30;
    localparam logic [GAIN_W-1:0]         RST_MAX_BRAKE    = 10'd20;
    localparam logic [GAIN_W-1:0]         RST_MAX_STEER    = 10'd470;
    localparam logic signed [LEVEL_W-1:0] RST_ON_LEVEL     = -16'sd25000;
    localparam logic signed [LEVEL_W-1:0] RST_OFF_LEVEL    = -16'sd5000;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd0;
    localparam logic [KIND_W-1:0] KIND_AXIS   = 2'd1;

    // axis and button numbers
    localparam logic [NUM_W-1:0] NUM_WHEEL     = 8'd0;
    localparam logic [NUM_W-1:0] NUM_CLUTCH    = 8'd1;
    localparam logic [NUM_W-1:0] NUM_THROTTLE  = 8'd2;
    localparam logic [NUM_W-1:0] NUM_BRAKE     = 8'd3;
    localparam logic [NUM_W-1:0] BTN_REARM_A   = 8'd22;
    localparam logic [NUM_W-1:0] BTN_REARM_B   = 8'd23;

    // drive mode
    typedef enum logic [MODE_W-1:0] {
        MODE_ESTOP = 2'd0,
        MODE_OFF   = 2'd1,
        MODE_ON    = 2'd2
    } t_mode;

    // configuration register set
    typedef struct packed {
        logic [GAIN_W-1:0]         max_throttle;
        logic [GAIN_W-1:0]         max_brake;
        logic [GAIN_W-1:0]         max_steer;
        logic signed [LEVEL_W-1:0] on_level;
        logic signed [LEVEL_W-1:0] off_level;
    } t_cfg;

    // clamp a wide command to the command range
    function automatic logic signed [CMD_W-1:0] sat_cmd(input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] lim_hi;
        logic signed [WIDE_W-1:0] lim_lo;
        lim_hi = WIDE_W'(CMD_LIMIT);
        lim_lo = WIDE_W'(-CMD_LIMIT);
        if (x > lim_hi) begin
            return CMD_W'(CMD_LIMIT);
        end else if (x < lim_lo) begin
            return CMD_W'(-CMD_LIMIT);
        end else begin
            return CMD_W'(x);
        end
    endfunction

endpackage

// File: hw/rtl/ddmm_in_if.sv
// ----------------------------------------------------------------------------
// ddmm_in_if: controller event channel
// Valid/ready channel carrying one controller event per beat.
// ----------------------------------------------------------------------------
interface ddmm_in_if;
    logic                                valid;
    logic                                ready;
    logic [ddmm_pkg::KIND_W-1:0]         event_kind;
    logic [ddmm_pkg::NUM_W-1:0]          event_number;
    logic signed [ddmm_pkg::VALUE_W-1:0] event_value;

    modport source (output valid, event_kind, event_number, event_value, input ready);
    modport sink   (input valid, event_kind, event_number, event_value, output ready);
endinterface

// File: hw/rtl/ddmm_out_if.sv
// ----------------------------------------------------------------------------
// ddmm_out_if: drive command channel
// Valid/ready channel carrying mode, throttle and steer per beat.
// ----------------------------------------------------------------------------
interface ddmm_out_if;
    logic                              valid;
    logic                              ready;
    logic [ddmm_pkg::MODE_W-1:0]       drive_mode;
    logic signed [ddmm_pkg::CMD_W-1:0] throttle_cmd;
    logic signed [ddmm_pkg::CMD_W-1:0] steer_cmd;

    modport source (output valid, drive_mode, throttle_cmd, steer_cmd, input ready);
    modport sink   (input valid, drive_mode, throttle_cmd, steer_cmd, output ready);
endinterface

// File: hw/rtl/ddmm_cfg_regs.sv
// ----------------------------------------------------------------------------
// ddmm_cfg_regs: configuration registers
// Holds gains and clutch thresholds, written through a plain write port.
// ----------------------------------------------------------------------------
module ddmm_cfg_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ddmm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ddmm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output ddmm_pkg::t_cfg                       o_cfg
);

    ddmm_pkg::t_cfg r_cfg;

    // register file, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_throttle <= ddmm_pkg::RST_MAX_THROTTLE;
            r_cfg.max_brake    <= ddmm_pkg::RST_MAX_BRAKE;
            r_cfg.max_steer    <= ddmm_pkg::RST_MAX_STEER;
            r_cfg.on_level     <= ddmm_pkg::RST_ON_LEVEL;
            r_cfg.off_level    <= ddmm_pkg::RST_OFF_LEVEL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ddmm_pkg::CFG_MAX_THROTTLE:
                    r_cfg.max_throttle <= i_cfg_data[ddmm_pkg::GAIN_W-1:0];
                ddmm_pkg::CFG_MAX_BRAKE:
                    r_cfg.max_brake <= i_cfg_data[ddmm_pkg::GAIN_W-1:0];
                ddmm_pkg::CFG_MAX_STEER:
                    r_cfg.max_steer <= i_cfg_data[ddmm_pkg::GAIN_W-1:0];
                ddmm_pkg::CFG_ON_LEVEL:
                    r_cfg.on_level <= $signed(i_cfg_data[ddmm_pkg::LEVEL_W-1:0]);
                ddmm_pkg::CFG_OFF_LEVEL:
                    r_cfg.off_level <= $signed(i_cfg_data[ddmm_pkg::LEVEL_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/ddmm_scale.sv
// ----------------------------------------------------------------------------
// ddmm_scale: pedal and wheel scaling
// Exact integer pedal term floor((65535-2v)*full/131070) and wheel term
// v*full/32767 truncated toward zero, dividers done as shift plus one fixup.
// ----------------------------------------------------------------------------
module ddmm_scale (
    input  logic signed [ddmm_pkg::VALUE_W-1:0] i_value,
    input  logic [ddmm_pkg::GAIN_W-1:0]         i_pedal_full,
    input  logic [ddmm_pkg::GAIN_W-1:0]         i_steer_full,
    output logic [ddmm_pkg::CMD_W-1:0]          o_pedal,
    output logic signed [ddmm_pkg::WIDE_W-1:0]  o_steer
);

    localparam int SPAN_W  = 17;
    localparam int PROD_W  = SPAN_W + ddmm_pkg::GAIN_W;
    localparam int HALF_W  = PROD_W - 1;
    localparam int PQ_W    = HALF_W - 16;
    localparam int SPROD_W = ddmm_pkg::VALUE_W + ddmm_pkg::GAIN_W + 1;
    localparam int SMAG_W  = SPROD_W - 1;
    localparam int SQ_W    = SMAG_W - 15;

    logic signed [SPAN_W:0]   span_s;
    logic [SPAN_W-1:0]        span;
    logic [PROD_W-1:0]        pedal_prod;
    logic [HALF_W-1:0]        pedal_half;
    logic [PQ_W-1:0]          pedal_q0;
    logic [16:0]              pedal_rem;

    logic signed [SPROD_W-1:0] steer_prod;
    logic [SMAG_W-1:0]         steer_mag;
    logic [SQ_W-1:0]           steer_q0;
    logic [15:0]               steer_rem;
    logic [SQ_W:0]             steer_q;

    // pedal: span is 65535 - 2v, always 1..131071
    assign span_s     = (SPAN_W+1)'(65535) - ((SPAN_W+1)'(i_value) <<< 1);
    assign span       = span_s[SPAN_W-1:0];
    assign pedal_prod = PROD_W'(span) * PROD_W'(i_pedal_full);

    // divide by 2 then by 65535: quotient estimate plus one correction step
    assign pedal_half = pedal_prod[PROD_W-1:1];
    assign pedal_q0   = pedal_half[HALF_W-1:16];
    assign pedal_rem  = 17'(pedal_half[15:0]) + 17'(pedal_q0);
    assign o_pedal    = ddmm_pkg::CMD_W'(pedal_q0)
                      + ddmm_pkg::CMD_W'(pedal_rem >= 17'd65535);

    // wheel: signed product, divide magnitude by 32767 the same way
    assign steer_prod = SPROD_W'(i_value) * $signed({1'b0, i_steer_full});
    assign steer_mag  = steer_prod[SPROD_W-1] ? SMAG_W'(-steer_prod) : SMAG_W'(steer_prod);
    assign steer_q0   = steer_mag[SMAG_W-1:15];
    assign steer_rem  = 16'(steer_mag[14:0]) + 16'(steer_q0);
    assign steer_q    = (SQ_W+1)'(steer_q0) + (SQ_W+1)'(steer_rem >= 16'd32767);

    // restore the sign, truncation toward zero
    assign o_steer = steer_prod[SPROD_W-1] ? -$signed(ddmm_pkg::WIDE_W'(steer_q))
                                           :  $signed(ddmm_pkg::WIDE_W'(steer_q));

endmodule

// File: hw/rtl/deadman_drive_mode_mapper.sv
// ----------------------------------------------------------------------------
// deadman_drive_mode_mapper: controller events to drive mode and commands
// Tracks estop/off/on from the clutch axis and rearm buttons, and scales
// the throttle, brake and wheel axes into saturated drive commands.
// ----------------------------------------------------------------------------
// Usage:
//   i_evt carries one controller event per beat (kind, number, value);
//   o_cmd returns exactly one beat per event: mode, throttle and steer
//   after that event. Gains and clutch thresholds are set through the
//   i_cfg_* write port while no event is in flight.
//   An event is captured in an input register, evaluated against the mode
//   and command registers, and its result is registered back into them and
//   shown on o_cmd. One event per cycle is sustained while o_cmd is ready;
//   the limit is a multiply plus constant divide between the input and
//   result registers.
//   Reset puts the block in mode off with zero commands, loads the default
//   gains and thresholds, and empties both stages.
//   When o_cmd is stalled the result holds; one more event may be taken
//   into the input register, after which i_evt.ready drops until the
//   result beat is taken.
// ----------------------------------------------------------------------------
module deadman_drive_mode_mapper (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    ddmm_in_if.sink                          i_evt,
    ddmm_out_if.source                       o_cmd,
    input  logic                             i_cfg_we,
    input  logic [ddmm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ddmm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    ddmm_pkg::t_cfg cfg;

    logic                                r_in_vld;
    logic [ddmm_pkg::KIND_W-1:0]         r_kind;
    logic [ddmm_pkg::NUM_W-1:0]          r_num;
    logic signed [ddmm_pkg::VALUE_W-1:0] r_value;

    logic                                r_out_vld;
    ddmm_pkg::t_mode                     r_mode;
    logic signed [ddmm_pkg::CMD_W-1:0]   r_thr;
    logic signed [ddmm_pkg::CMD_W-1:0]   r_str;

    ddmm_pkg::t_mode                     n_mode;
    logic signed [ddmm_pkg::CMD_W-1:0]   n_thr;
    logic signed [ddmm_pkg::CMD_W-1:0]   n_str;

    logic                                out_free;
    logic                                adv;
    logic                                is_axis;
    logic                                is_button;
    logic                                is_rearm;
    logic [ddmm_pkg::GAIN_W-1:0]         pedal_full;
    logic [ddmm_pkg::CMD_W-1:0]          pedal;
    logic signed [ddmm_pkg::WIDE_W-1:0]  pedal_s;
    logic signed [ddmm_pkg::WIDE_W-1:0]  steer;

    // configuration registers
    ddmm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // handshake: result slot frees when empty or taken this cycle
    assign out_free    = !r_out_vld || o_cmd.ready;
    assign adv         = r_in_vld && out_free;
    assign i_evt.ready = !r_in_vld || out_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_evt.ready) begin
            r_in_vld <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_kind  <= i_evt.event_kind;
            r_num   <= i_evt.event_number;
            r_value <= i_evt.event_value;
        end
    end

    // event decode
    assign is_axis   = (r_kind == ddmm_pkg::KIND_AXIS);
    assign is_button = (r_kind == ddmm_pkg::KIND_BUTTON);
    assign is_rearm  = is_button && ((r_num == ddmm_pkg::BTN_REARM_A) ||
                                     (r_num == ddmm_pkg::BTN_REARM_B));

    // pedal and wheel scaling
    assign pedal_full = (r_num == ddmm_pkg::NUM_BRAKE) ? cfg.max_brake : cfg.max_throttle;

    ddmm_scale u_scale (
        .i_value      (r_value),
        .i_pedal_full (pedal_full),
        .i_steer_full (cfg.max_steer),
        .o_pedal      (pedal),
        .o_steer      (steer)
    );

    assign pedal_s = $signed(ddmm_pkg::WIDE_W'(pedal));

    // mode and command update
    always_comb begin
        n_mode = r_mode;
        n_thr  = r_thr;
        n_str  = r_str;
        unique case (r_mode)
            ddmm_pkg::MODE_ON: begin
                if (is_axis) begin
                    unique case (r_num)
                        ddmm_pkg::NUM_CLUTCH: begin
                            if (r_value > cfg.off_level) begin
                                n_mode = ddmm_pkg::MODE_ESTOP;
                            end
                        end
                        ddmm_pkg::NUM_THROTTLE: n_thr = ddmm_pkg::sat_cmd(pedal_s);
                        ddmm_pkg::NUM_BRAKE:    n_thr = ddmm_pkg::sat_cmd(-pedal_s);
                        ddmm_pkg::NUM_WHEEL:    n_str = ddmm_pkg::sat_cmd(steer);
                        default: begin
                        end
                    endcase
                end
            end
            ddmm_pkg::MODE_ESTOP, ddmm_pkg::MODE_OFF: begin
                // estop rearm first, anything else falls to the off rules
                priority if ((r_mode == ddmm_pkg::MODE_ESTOP) && is_rearm) begin
                    n_mode = ddmm_pkg::MODE_OFF;
                end else if (is_axis && (r_num == ddmm_pkg::NUM_CLUTCH) &&
                             (r_value < cfg.on_level)) begin
                    n_mode = ddmm_pkg::MODE_ON;
                end else begin
                    n_mode = r_mode;
                end
            end
            default: begin
            end
        endcase
    end

    // state doubles as the result register, it only moves when the slot frees
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_mode    <= ddmm_pkg::MODE_OFF;
            r_thr     <= '0;
            r_str     <= '0;
        end else begin
            if (adv) begin
                r_out_vld <= 1'b1;
                r_mode    <= n_mode;
                r_thr     <= n_thr;
                r_str     <= n_str;
            end else if (o_cmd.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // result beat
    assign o_cmd.valid        = r_out_vld;
    assign o_cmd.drive_mode   = r_mode;
    assign o_cmd.throttle_cmd = r_thr;
    assign o_cmd.steer_cmd    = r_str;

endmodule

// File: tb/tb_deadman_drive_mode_mapper.sv
// ----------------------------------------------------------------------------
// tb_deadman_drive_mode_mapper: self-checking bench for the drive mode mapper
// Drives controller events through the valid/ready event channel, predicts
// mode, throttle and steer for every accepted event with an in-bench model,
// and compares each command beat in order. Covers the mode rules, command
// extremes, a long output stall and random drive cycles under several gain
// and clutch threshold settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_deadman_drive_mode_mapper;
    import ddmm_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int SETTLE_CYCLES   = 4;
    localparam int SEGMENT_EVENTS  = 300;
    localparam int PEDAL_SPAN      = 65535;
    localparam int WHEEL_FULL      = 32767;
    localparam int GAIN_MAX        = 1023;
    localparam int LEVEL_MIN       = -32768;
    localparam int LEVEL_MAX       = 32767;

    localparam logic [KIND_W-1:0]         KIND_OTHER = 2'd2;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN  = 16'sh8000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX  = 16'sh7FFF;
    localparam logic signed [VALUE_W-1:0] VALUE_ZERO = 16'sh0000;

    typedef struct {
        t_mode                   mode;
        logic signed [CMD_W-1:0] throttle;
        logic signed [CMD_W-1:0] steer;
    } t_cmd_beat;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    ddmm_in_if  evt_if ();
    ddmm_out_if cmd_if ();

    deadman_drive_mode_mapper dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (evt_if),
        .o_cmd      (cmd_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // bench copy of mode, commands and register settings
    t_mode                   drive_state    = MODE_OFF;
    logic signed [CMD_W-1:0] throttle_state = '0;
    logic signed [CMD_W-1:0] steer_state    = '0;
    int                      gain_throttle  = int'(RST_MAX_THROTTLE);
    int                      gain_brake     = int'(RST_MAX_BRAKE);
    int                      gain_steer     = int'(RST_MAX_STEER);
    int                      level_engage   = int'(RST_ON_LEVEL);
    int                      level_trip     = int'(RST_OFF_LEVEL);

    t_cmd_beat pending_cmds[$];

    int send_idle_pct = 12;
    int recv_idle_pct = 71;
    int hold_left     = 0;
    int err_cnt       = 0;
    int sent_cnt      = 0;
    int checked_cnt   = 0;
    int settings_cnt  = 0;
    int engage_cnt    = 0;
    int trip_cnt      = 0;
    int rearm_cnt     = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // command clamp to +/-1023
    function automatic logic signed [CMD_W-1:0] clamp_cmd(input longint x);
        if (x > CMD_LIMIT) return CMD_W'(CMD_LIMIT);
        if (x < -CMD_LIMIT) return CMD_W'(-CMD_LIMIT);
        return CMD_W'(x);
    endfunction

    // pedal travel scaled by a gain; numerator is never negative so this is a floor
    function automatic longint pedal_scale(input longint v, input int gain);
        return ((PEDAL_SPAN - 2 * v) * gain) / (2 * PEDAL_SPAN);
    endfunction

    // next mode and commands after one event
    function automatic t_cmd_beat predict_command(input logic [KIND_W-1:0] kind,
                                                  input logic [NUM_W-1:0] num,
                                                  input logic signed [VALUE_W-1:0] value);
        longint    v;
        t_cmd_beat beat;
        v = longint'(value);
        if (drive_state == MODE_ON) begin
            if (kind == KIND_AXIS) begin
                case (num)
                    NUM_CLUTCH: begin
                        if (v > level_trip) begin
                            drive_state = MODE_ESTOP;
                            trip_cnt++;
                        end
                    end
                    NUM_THROTTLE: throttle_state = clamp_cmd(pedal_scale(v, gain_throttle));
                    NUM_BRAKE:    throttle_state = clamp_cmd(-pedal_scale(v, gain_brake));
                    NUM_WHEEL:    steer_state = clamp_cmd((v * gain_steer) / WHEEL_FULL);
                    default: ;
                endcase
            end
        end else if (drive_state == MODE_ESTOP && kind == KIND_BUTTON &&
                     (num == BTN_REARM_A || num == BTN_REARM_B)) begin
            drive_state = MODE_OFF;
            rearm_cnt++;
        end else if (kind == KIND_AXIS && num == NUM_CLUTCH && v < level_engage) begin
            // estop falls through to the off rules here
            drive_state = MODE_ON;
            engage_cnt++;
        end
        beat.mode     = drive_state;
        beat.throttle = throttle_state;
        beat.steer    = steer_state;
        return beat;
    endfunction

    // register write as seen by the bench copy; unused indexes do nothing
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_MAX_THROTTLE: gain_throttle = int'(data[GAIN_W-1:0]);
            CFG_MAX_BRAKE:    gain_brake    = int'(data[GAIN_W-1:0]);
            CFG_MAX_STEER:    gain_steer    = int'(data[GAIN_W-1:0]);
            CFG_ON_LEVEL:     level_engage  = int'($signed(data));
            CFG_OFF_LEVEL:    level_trip    = int'($signed(data));
            default: ;
        endcase
    endfunction

    task automatic check_field(input string what, input logic signed [CMD_W-1:0] want,
                               input logic signed [CMD_W-1:0] got);
        if (got !== want) begin
            err_cnt++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // command beat checker and event predictor
    initial begin
        t_cmd_beat want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (cmd_if.valid && cmd_if.ready) begin
                    if (pending_cmds.size() == 0) begin
                        err_cnt++;
                        $display("%0t: unexpected command beat: mode %0d throttle %0d steer %0d",
                                 $time, cmd_if.drive_mode, cmd_if.throttle_cmd,
                                 cmd_if.steer_cmd);
                    end else begin
                        want = pending_cmds.pop_front();
                        check_field("drive_mode", CMD_W'(want.mode),
                                    CMD_W'(cmd_if.drive_mode));
                        check_field("throttle_cmd", want.throttle, cmd_if.throttle_cmd);
                        check_field("steer_cmd", want.steer, cmd_if.steer_cmd);
                        checked_cnt++;
                    end
                end
                if (evt_if.valid && evt_if.ready) begin
                    pending_cmds.push_back(predict_command(evt_if.event_kind,
                                                           evt_if.event_number,
                                                           evt_if.event_value));
                end
            end
        end
    end

    // command receiver: random idling or a counted hold-off
    initial begin
        cmd_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                cmd_if.ready <= 1'b0;
                hold_left--;
            end else begin
                cmd_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog on cycles with no beat and no register write
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || cfg_we || (evt_if.valid && evt_if.ready) ||
                (cmd_if.valid && cmd_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_deadman_drive_mode_mapper failed");
        $finish;
    end

    // offer one event, with random idle cycles ahead of it
    task automatic send_event(input logic [KIND_W-1:0] kind, input logic [NUM_W-1:0] num,
                              input logic signed [VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            evt_if.valid        <= 1'b0;
            evt_if.event_kind   <= KIND_W'($urandom);
            evt_if.event_number <= NUM_W'($urandom);
            evt_if.event_value  <= VALUE_W'($urandom);
            @(posedge i_clk);
        end
        evt_if.valid        <= 1'b1;
        evt_if.event_kind   <= kind;
        evt_if.event_number <= num;
        evt_if.event_value  <= value;
        @(posedge i_clk);
        while (evt_if.ready !== 1'b1) @(posedge i_clk);
        sent_cnt++;
    endtask

    // stop offering and wait for every predicted beat
    task automatic drain_results();
        evt_if.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_cmds.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // gain word with junk in the unused upper bits
    function automatic logic [CFG_DATA_W-1:0] gain_word(input int gain);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        return {junk[CFG_DATA_W-1:GAIN_W], GAIN_W'(gain)};
    endfunction

    // write all five registers plus one unused index, one per cycle
    task automatic load_settings(input int thr, input int brk, input int str,
                                 input int on_lvl, input int off_lvl);
        logic [CFG_IDX_W-1:0]  idx_list[6];
        logic [CFG_DATA_W-1:0] data_list[6];
        idx_list  = '{CFG_MAX_THROTTLE, CFG_MAX_BRAKE, CFG_MAX_STEER, CFG_ON_LEVEL,
                      CFG_OFF_LEVEL, CFG_OFF_LEVEL + CFG_IDX_W'(1 + $urandom_range(2))};
        data_list = '{gain_word(thr), gain_word(brk), gain_word(str),
                      CFG_DATA_W'(on_lvl), CFG_DATA_W'(off_lvl), CFG_DATA_W'($urandom)};
        for (int i = 0; i < 6; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= idx_list[i];
            cfg_data <= data_list[i];
            apply_reg(idx_list[i], data_list[i]);
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        settings_cnt++;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(negedge i_clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_axis_value();
        case ($urandom_range(7))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2: return VALUE_ZERO;
            3: return -16'sd1;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // clutch positions strictly beyond a threshold, pinned when none exist
    function automatic logic signed [VALUE_W-1:0] below_level(input int lvl);
        if (lvl <= LEVEL_MIN) return VALUE_MIN;
        return VALUE_W'(LEVEL_MIN + int'($urandom_range(lvl - LEVEL_MIN - 1)));
    endfunction

    function automatic logic signed [VALUE_W-1:0] above_level(input int lvl);
        if (lvl >= LEVEL_MAX) return VALUE_MAX;
        return VALUE_W'(lvl + 1 + int'($urandom_range(LEVEL_MAX - lvl - 1)));
    endfunction

    // any kind, mostly near the numbers that matter
    task automatic send_noise_event();
        logic [NUM_W-1:0] num;
        case ($urandom_range(2))
            0: num = NUM_W'($urandom);
            1: num = NUM_W'($urandom_range(3));
            default: num = $urandom_range(1) ? BTN_REARM_B : BTN_REARM_A;
        endcase
        send_event(KIND_W'($urandom), num, pick_axis_value());
    endtask

    // engage, drive the axes, usually trip and rearm
    task automatic run_drive_cycle();
        int steps;
        if ($urandom_range(9) == 0) send_event(KIND_AXIS, NUM_CLUTCH, VALUE_W'(level_engage));
        send_event(KIND_AXIS, NUM_CLUTCH, below_level(level_engage));
        steps = $urandom_range(12, 1);
        repeat (steps) begin
            case ($urandom_range(9))
                0: send_noise_event();
                1: send_event(KIND_AXIS, NUM_CLUTCH, pick_axis_value());
                2, 3, 4: send_event(KIND_AXIS, NUM_WHEEL, pick_axis_value());
                5, 6: send_event(KIND_AXIS, NUM_BRAKE, pick_axis_value());
                default: send_event(KIND_AXIS, NUM_THROTTLE, pick_axis_value());
            endcase
        end
        if ($urandom_range(4) != 0) begin
            if ($urandom_range(9) == 0) send_event(KIND_AXIS, NUM_CLUTCH, VALUE_W'(level_trip));
            send_event(KIND_AXIS, NUM_CLUTCH, above_level(level_trip));
            if ($urandom_range(3) == 0) begin
                send_event(KIND_BUTTON, NUM_W'($urandom_range(BTN_REARM_A - 1)),
                           VALUE_W'($urandom));
            end
            send_event(KIND_BUTTON, $urandom_range(1) ? BTN_REARM_B : BTN_REARM_A,
                       VALUE_W'($urandom));
        end
    endtask

    task automatic run_random_segment(input int n_events);
        int stop_at;
        stop_at = sent_cnt + n_events;
        while (sent_cnt < stop_at) begin
            if ($urandom_range(99) < 80) begin
                run_drive_cycle();
            end else begin
                repeat ($urandom_range(4, 1)) send_noise_event();
            end
        end
        drain_results();
    endtask

    // mode rules under reset settings
    task automatic test_mode_rules();
        send_event(KIND_OTHER, NUM_CLUTCH, VALUE_MIN);
        send_event(KIND_AXIS, NUM_THROTTLE, VALUE_MIN);
        send_event(KIND_AXIS, NUM_CLUTCH, RST_ON_LEVEL);
        send_event(KIND_AXIS, NUM_CLUTCH, RST_ON_LEVEL - 16'sd1);
        send_event(KIND_AXIS, NUM_THROTTLE, VALUE_ZERO);
        send_event(KIND_AXIS, NUM_CLUTCH, RST_OFF_LEVEL);
        send_event(KIND_AXIS, NUM_CLUTCH, RST_OFF_LEVEL + 16'sd1);
        // wrong buttons leave estop alone
        send_event(KIND_BUTTON, BTN_REARM_A - 8'd1, VALUE_MAX);
        send_event(KIND_BUTTON, BTN_REARM_B + 8'd1, VALUE_MAX);
        // low clutch in estop engages directly
        send_event(KIND_AXIS, NUM_CLUTCH, VALUE_MIN);
        send_event(KIND_AXIS, NUM_CLUTCH, VALUE_MAX);
        send_event(KIND_BUTTON, BTN_REARM_A, VALUE_ZERO);
        send_event(KIND_BUTTON, BTN_REARM_B, VALUE_MAX);
        send_event(KIND_AXIS, NUM_CLUTCH, VALUE_MIN);
        send_event(KIND_AXIS, NUM_CLUTCH, VALUE_MAX);
        send_event(KIND_BUTTON, BTN_REARM_B, VALUE_MIN);
        drain_results();
    endtask

    // full-scale gains and the tightest clutch thresholds
    task automatic test_command_extremes();
        load_settings(GAIN_MAX, GAIN_MAX, GAIN_MAX, LEVEL_MIN + 1, LEVEL_MAX - 1);
        send_event(KIND_AXIS, NUM_CLUTCH, VALUE_MIN);
        send_event(KIND_AXIS, NUM_THROTTLE, VALUE_MIN);
        send_event(KIND_AXIS, NUM_THROTTLE, VALUE_MAX);
        send_event(KIND_AXIS, NUM_BRAKE, VALUE_MIN);
        send_event(KIND_AXIS, NUM_BRAKE, VALUE_MAX);
        send_event(KIND_AXIS, NUM_WHEEL, VALUE_MIN);
        send_event(KIND_AXIS, NUM_WHEEL, VALUE_MAX);
        send_event(KIND_AXIS, NUM_W'(8'hFF), VALUE_MIN);
        send_event(KIND_BUTTON, BTN_REARM_A, VALUE_MAX);
        send_event(KIND_OTHER, NUM_THROTTLE, VALUE_MIN);
        send_event(KIND_AXIS, NUM_CLUTCH, VALUE_MAX);
        drain_results();
    endtask

    // long output hold-off while events keep coming, so the input stalls
    task automatic test_input_stall();
        int stop_at;
        set_idling(0, 0);
        hold_left = HOLD_OFF_CYCLES;
        stop_at = sent_cnt + 30;
        while (sent_cnt < stop_at) run_drive_cycle();
        drain_results();
        set_idling(12, 71);
    endtask

    // random drive traffic over several settings and idling patterns
    task automatic test_random_traffic();
        load_settings($urandom_range(GAIN_MAX), $urandom_range(GAIN_MAX),
                      $urandom_range(GAIN_MAX), int'(RST_ON_LEVEL), int'(RST_OFF_LEVEL));
        run_random_segment(SEGMENT_EVENTS);
        load_settings(GAIN_MAX, GAIN_MAX, GAIN_MAX, LEVEL_MAX, LEVEL_MIN);
        run_random_segment(SEGMENT_EVENTS);

        set_idling(71, 12);
        load_settings(0, 0, 0, LEVEL_MIN + 1, LEVEL_MAX);
        run_random_segment(SEGMENT_EVENTS);
        load_settings($urandom_range(GAIN_MAX), $urandom_range(GAIN_MAX),
                      $urandom_range(GAIN_MAX), LEVEL_MIN + int'($urandom_range(65535)),
                      LEVEL_MIN + int'($urandom_range(65535)));
        run_random_segment(SEGMENT_EVENTS);

        set_idling(0, 0);
        load_settings($urandom_range(7), $urandom_range(7), $urandom_range(7),
                      LEVEL_MIN + int'($urandom_range(32768)),
                      int'($urandom_range(LEVEL_MAX)) - 16384);
        run_random_segment(SEGMENT_EVENTS);
        load_settings(int'(RST_MAX_THROTTLE), int'(RST_MAX_BRAKE), int'(RST_MAX_STEER),
                      int'(RST_ON_LEVEL), int'(RST_OFF_LEVEL));
        run_random_segment(SEGMENT_EVENTS);
    endtask

    // reset, test sequence, verdict
    initial begin
        i_rst_n             <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= '0;
        cfg_data            <= '0;
        evt_if.valid        <= 1'b0;
        evt_if.event_kind   <= '0;
        evt_if.event_number <= '0;
        evt_if.event_value  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_mode_rules();
        test_command_extremes();
        test_input_stall();
        test_random_traffic();

        $display("run covered %0d events and %0d command beats over %0d register settings",
                 sent_cnt, checked_cnt, settings_cnt);
        $display("mode changes seen: %0d engage, %0d trip to estop, %0d rearm",
                 engage_cnt, trip_cnt, rearm_cnt);
        if (err_cnt == 0) begin
            $display("tb_deadman_drive_mode_mapper passed");
        end else begin
            $display("tb_deadman_drive_mode_mapper failed");
        end
        $finish;
    end

endmodule
